>>> hdl/rotation_matrix_to_quaternion_unit_macros.svh
// Assertion macros for the rotation matrix to quaternion unit.
// Used by the port checker; needs a clk and rst in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// checked only out of reset
`define RMQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rmq check failed");

// checked at every edge, reset included
`define RMQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rmq check failed");

`endif

>>> hdl/rmq_pkg.sv
// Shared constants for the rotation matrix to quaternion unit.
// No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W          = 16;
  localparam int PART_W        = 16;
  localparam int W_W           = 15;
  localparam int PART_MAX      = 32767;
  localparam int LANES         = 4;

  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  localparam int SIGN_X = 0;
  localparam int SIGN_Y = 1;
  localparam int SIGN_Z = 2;
  localparam int SIGN_W = 3;

endpackage

>>> hdl/rmq_isqrt.sv
// Four-lane pipelined integer square root, one root bit per stage.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_isqrt import rmq_pkg::*; #(
  parameter int ROOT_W = 16,
  parameter int SIDE_W = SIGN_W
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [LANES-1:0][2*ROOT_W-1:0]       rad,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [LANES-1:0][ROOT_W-1:0]         root,
  output logic [SIDE_W-1:0]                    side_out
);

  localparam int REM_W = ROOT_W + 2;
  localparam int RAD_W = 2 * ROOT_W;

  logic [ROOT_W-1:0] valid;
  logic [ROOT_W-1:0] load;

  logic [LANES-1:0][REM_W-1:0]  rem_q  [ROOT_W];
  logic [LANES-1:0][ROOT_W-1:0] root_q [ROOT_W];
  logic [LANES-1:0][RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0]            side_q [ROOT_W];

  assign load[ROOT_W-1] = !valid[ROOT_W-1] || out_ready;

  genvar s;
  generate
    for (s = 0; s < ROOT_W; s++) begin : g_stage
      logic                         prev_v;
      logic [LANES-1:0][REM_W-1:0]  prev_rem;
      logic [LANES-1:0][ROOT_W-1:0] prev_root;
      logic [LANES-1:0][RAD_W-1:0]  prev_rad;
      logic [SIDE_W-1:0]            prev_side;
      logic [LANES-1:0][REM_W+1:0]  rem_sh;
      logic [LANES-1:0][REM_W+1:0]  trial;
      logic [LANES-1:0][REM_W+1:0]  diff;
      logic [LANES-1:0][REM_W-1:0]  rem_next;
      logic [LANES-1:0][ROOT_W-1:0] root_next;
      logic [LANES-1:0][RAD_W-1:0]  rad_next;

      if (s == 0) begin : g_first
        assign prev_v    = in_valid;
        assign prev_rem  = '0;
        assign prev_root = '0;
        assign prev_rad  = rad;
        assign prev_side = side_in;
      end else begin : g_next
        assign prev_v    = valid[s-1];
        assign prev_rem  = rem_q[s-1];
        assign prev_root = root_q[s-1];
        assign prev_rad  = rad_q[s-1];
        assign prev_side = side_q[s-1];
      end

      if (s < ROOT_W - 1) begin : g_load
        assign load[s] = !valid[s] || load[s+1];
      end

      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_sh[l]   = {prev_rem[l], prev_rad[l][RAD_W-1 -: 2]};
          trial[l]    = {2'b00, prev_root[l], 2'b01};
          diff[l]     = rem_sh[l] - trial[l];
          rad_next[l] = {prev_rad[l][RAD_W-3:0], 2'b00};
          if (rem_sh[l] >= trial[l]) begin
            rem_next[l]  = diff[l][REM_W-1:0];
            root_next[l] = {prev_root[l][ROOT_W-2:0], 1'b1};
          end else begin
            rem_next[l]  = rem_sh[l][REM_W-1:0];
            root_next[l] = {prev_root[l][ROOT_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          valid[s] <= 1'b0;
        end else if (load[s]) begin
          valid[s] <= prev_v;
        end
        if (load[s] && prev_v) begin
          rem_q[s]  <= rem_next;
          root_q[s] <= root_next;
          rad_q[s]  <= rad_next;
          side_q[s] <= prev_side;
        end
      end
    end
  endgenerate

  assign in_ready  = load[0];
  assign out_valid = valid[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign side_out  = side_q[ROOT_W-1];

endmodule

>>> hdl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion unit, top level.
// Depends on rmq_pkg and rmq_isqrt.
//
// Usage:
//   Matrix channel: matrix_valid/matrix_ready carry nine signed fixed point
//   elements (rows right, up, at). Quaternion channel: quat_valid/quat_ready
//   carry quat_w (unsigned) and signed quat_x, quat_y, quat_z.
//   A transfer happens on a rising edge with valid and ready both high.
//   A matrix passes through stage A, the square root pipeline and the output
//   register; the root is ROOT_W bits wide, half the radicand width rounded
//   up. One matrix is taken every cycle while matrix_ready is high; the
//   four square roots run in lockstep through a pipeline, one root bit per stage.
//   Each stage holds its own valid bit, so when the receiver stalls the
//   pipeline keeps filling its bubbles and matrix_ready drops only when
//   every stage holds an item. Nothing is lost or repeated under a stall.
//   Synchronous reset clears all valid bits; payload registers keep data.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     matrix_valid,
  output logic                     matrix_ready,
  input  logic signed [IN_W-1:0]   right_x,
  input  logic signed [IN_W-1:0]   right_y,
  input  logic signed [IN_W-1:0]   right_z,
  input  logic signed [IN_W-1:0]   up_x,
  input  logic signed [IN_W-1:0]   up_y,
  input  logic signed [IN_W-1:0]   up_z,
  input  logic signed [IN_W-1:0]   at_x,
  input  logic signed [IN_W-1:0]   at_y,
  input  logic signed [IN_W-1:0]   at_z,
  output logic                     quat_valid,
  input  logic                     quat_ready,
  output logic [W_W-1:0]           quat_w,
  output logic signed [PART_W-1:0] quat_x,
  output logic signed [PART_W-1:0] quat_y,
  output logic signed [PART_W-1:0] quat_z
);

  localparam int MAG_W   = (FRAC_BITS > 17) ? FRAC_BITS : 17;
  localparam int SUM_W   = MAG_W + 2;
  localparam int CLAMP_W = SUM_W - 1;
  localparam int RAD_W   = CLAMP_W + FRAC_BITS;
  localparam int ROOT_W  = (RAD_W + 1) / 2;
  localparam int CMP_W   = (ROOT_W > PART_W) ? ROOT_W : PART_W;
  localparam int DIFF_W  = IN_W + 1;

  // stage A: four sums, clamp, sign of the differences
  logic signed [SUM_W-1:0] one_c;
  logic signed [SUM_W-1:0] e00, e11, e22;
  logic signed [SUM_W-1:0] sum [LANES];
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [LANES-1:0][CLAMP_W-1:0] clamp;

  assign one_c = SUM_W'(1) <<< FRAC_BITS;
  assign e00   = SUM_W'(right_x);
  assign e11   = SUM_W'(up_y);
  assign e22   = SUM_W'(at_z);
  assign dx    = DIFF_W'(at_y) - DIFF_W'(up_z);
  assign dy    = DIFF_W'(right_z) - DIFF_W'(at_x);
  assign dz    = DIFF_W'(up_x) - DIFF_W'(right_y);

  always_comb begin
    sum[LANE_W] = one_c + e00 + e11 + e22;
    sum[LANE_X] = one_c + e00 - e11 - e22;
    sum[LANE_Y] = one_c - e00 + e11 - e22;
    sum[LANE_Z] = one_c - e00 - e11 + e22;
    for (int l = 0; l < LANES; l++) begin
      clamp[l] = sum[l][SUM_W-1] ? '0 : sum[l][CLAMP_W-1:0];
    end
  end

  logic                          a_valid;
  logic                          a_load;
  logic [LANES-1:0][CLAMP_W-1:0] a_sum;
  logic [SIGN_W-1:0]             a_neg;

  logic                              sq_in_ready;
  logic [LANES-1:0][2*ROOT_W-1:0]    sq_rad;
  logic                              sq_valid;
  logic                              q_load;
  logic [LANES-1:0][ROOT_W-1:0]      sq_root;
  logic [SIGN_W-1:0]                 sq_neg;

  assign a_load       = !a_valid || sq_in_ready;
  assign matrix_ready = a_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= matrix_valid;
    end
    if (a_load && matrix_valid) begin
      a_sum         <= clamp;
      a_neg[SIGN_X] <= dx[DIFF_W-1];
      a_neg[SIGN_Y] <= dy[DIFF_W-1];
      a_neg[SIGN_Z] <= dz[DIFF_W-1];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sq_rad[l] = (2*ROOT_W)'(a_sum[l]) << FRAC_BITS;
    end
  end

  rmq_isqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W (SIGN_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (sq_in_ready),
    .rad       (sq_rad),
    .side_in   (a_neg),
    .out_valid (sq_valid),
    .out_ready (q_load),
    .root      (sq_root),
    .side_out  (sq_neg)
  );

  // output stage: halve, saturate, apply sign
  logic [LANES-1:0][CMP_W-1:0]  half;
  logic [LANES-1:0][W_W-1:0]    mag;
  logic [PART_W-1:0]            px, py, pz;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      half[l] = CMP_W'(sq_root[l] >> 1);
      if (half[l] > CMP_W'(PART_MAX)) begin
        mag[l] = W_W'(PART_MAX);
      end else begin
        mag[l] = half[l][W_W-1:0];
      end
    end
    px = sq_neg[SIGN_X] ? (PART_W'(0) - {1'b0, mag[LANE_X]}) : {1'b0, mag[LANE_X]};
    py = sq_neg[SIGN_Y] ? (PART_W'(0) - {1'b0, mag[LANE_Y]}) : {1'b0, mag[LANE_Y]};
    pz = sq_neg[SIGN_Z] ? (PART_W'(0) - {1'b0, mag[LANE_Z]}) : {1'b0, mag[LANE_Z]};
  end

  assign q_load = !quat_valid || quat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (q_load) begin
      quat_valid <= sq_valid;
    end
    if (q_load && sq_valid) begin
      quat_w <= mag[LANE_W];
      quat_x <= px;
      quat_y <= py;
      quat_z <= pz;
    end
  end

endmodule

>>> hdl/rmq_checker.sv
// Port-level checker for the rotation matrix to quaternion unit, with bind.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_unit_macros.svh.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_unit_macros.svh"

module rmq_checker import rmq_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     matrix_valid,
  input logic                     matrix_ready,
  input logic                     quat_valid,
  input logic                     quat_ready,
  input logic [W_W-1:0]           quat_w,
  input logic signed [PART_W-1:0] quat_x,
  input logic signed [PART_W-1:0] quat_y,
  input logic signed [PART_W-1:0] quat_z
);

  // offered matrix stays offered until its transfer
  `RMQ_ASSERT(a_in_hold, matrix_valid && !matrix_ready |=> matrix_valid)

  // stalled result holds until its transfer
  `RMQ_ASSERT(a_out_hold, quat_valid && !quat_ready |=> quat_valid && $stable(quat_w) && $stable(quat_x) && $stable(quat_y) && $stable(quat_z))

  // reset empties the pipeline
  `RMQ_ASSERT_ALWAYS(a_reset_empty, rst |=> !quat_valid && matrix_ready)

  // input backpressure only comes from a stalled output
  `RMQ_ASSERT(a_ready_cause, !matrix_ready |-> quat_valid && !quat_ready)

  // saturated, symmetric parts never reach the most negative code
  `RMQ_ASSERT(a_part_range, quat_valid |-> quat_x != 16'sh8000 && quat_y != 16'sh8000 && quat_z != 16'sh8000)

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk          (clk),
  .rst          (rst),
  .matrix_valid (matrix_valid),
  .matrix_ready (matrix_ready),
  .quat_valid   (quat_valid),
  .quat_ready   (quat_ready),
  .quat_w       (quat_w),
  .quat_x       (quat_x),
  .quat_y       (quat_y),
  .quat_z       (quat_z)
);

>>> tb/tb_top.sv
// Self-checking testbench for rotation_matrix_to_quaternion_unit.
// Predicts each quaternion from the matrix in integer math and checks results in order.
// Depends on rmq_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import rmq_pkg::*;

  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int LATENCY     = 18;
  localparam int CYCLE_LIMIT = 500000;

  // elements in row order: m00 m01 m02 m10 m11 m12 m20 m21 m22
  typedef logic [0:8][IN_W-1:0] matrix_t;

  typedef struct packed {
    logic [W_W-1:0]           w;
    logic signed [PART_W-1:0] x;
    logic signed [PART_W-1:0] y;
    logic signed [PART_W-1:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic matrix_valid = 1'b0;
  logic matrix_ready;
  logic signed [IN_W-1:0] right_x = '0, right_y = '0, right_z = '0;
  logic signed [IN_W-1:0] up_x = '0, up_y = '0, up_z = '0;
  logic signed [IN_W-1:0] at_x = '0, at_y = '0, at_z = '0;
  logic quat_valid;
  logic quat_ready = 1'b0;
  logic [W_W-1:0] quat_w;
  logic signed [PART_W-1:0] quat_x, quat_y, quat_z;

  quat_t       pending_quats[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          no_gaps = 1'b0;
  bit          no_stalls = 1'b0;

  rotation_matrix_to_quaternion_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .matrix_valid (matrix_valid),
    .matrix_ready (matrix_ready),
    .right_x      (right_x),
    .right_y      (right_y),
    .right_z      (right_z),
    .up_x         (up_x),
    .up_y         (up_y),
    .up_z         (up_z),
    .at_x         (at_x),
    .at_y         (at_y),
    .at_z         (at_z),
    .quat_valid   (quat_valid),
    .quat_ready   (quat_ready),
    .quat_w       (quat_w),
    .quat_x       (quat_x),
    .quat_y       (quat_y),
    .quat_z       (quat_z)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // floor(sqrt(s * 2^FRAC_BITS)) / 2, clamped below at zero and saturated
  function automatic longint half_root_q(input longint s);
    longint unsigned n, root, t;
    if (s < 0) s = 0;
    n = longint'(s) << FRAC_BITS;
    root = 0;
    for (int b = 24; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= n) root = t;
    end
    root = root >> 1;
    if (root > PART_MAX) root = PART_MAX;
    return longint'(root);
  endfunction

  function automatic logic signed [PART_W-1:0] apply_sign(input longint mag, input longint diff);
    longint v;
    v = (diff < 0) ? -mag : mag;
    return v[PART_W-1:0];
  endfunction

  function automatic quat_t predict_quat(input matrix_t mat);
    longint m [9];
    longint one, mag;
    quat_t q;
    one = longint'(1) << FRAC_BITS;
    for (int k = 0; k < 9; k++) m[k] = signed'(mat[k]);
    mag = half_root_q(one + m[0] + m[4] + m[8]);
    q.w = mag[W_W-1:0];
    q.x = apply_sign(half_root_q(one + m[0] - m[4] - m[8]), m[7] - m[5]);
    q.y = apply_sign(half_root_q(one - m[0] + m[4] - m[8]), m[2] - m[6]);
    q.z = apply_sign(half_root_q(one - m[0] - m[4] + m[8]), m[3] - m[1]);
    return q;
  endfunction

  // entered right after the edge that took the previous transfer
  task automatic send_matrix(input matrix_t mat);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) matrix_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    right_x <= mat[0]; right_y <= mat[1]; right_z <= mat[2];
    up_x    <= mat[3]; up_y    <= mat[4]; up_z    <= mat[5];
    at_x    <= mat[6]; at_y    <= mat[7]; at_z    <= mat[8];
    matrix_valid <= 1'b1;
    do @(posedge clk); while (!matrix_ready);
    pending_quats.push_back(predict_quat(mat));
  endtask

  task automatic wait_drained();
    @(negedge clk) matrix_valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] corner_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd16384;
      3: return 16'sd16384;
      4: return -16'sd1;
      5: return 16'sd1;
      6: return 16'sh5555;
      default: return 16'sd0;
    endcase
  endfunction

  task automatic test_directed();
    send_matrix(matrix_t'{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
    send_matrix(matrix_t'{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_matrix({9{16'sh7fff}});
    send_matrix({9{16'sh8000}});
    send_matrix(matrix_t'{-32768, 5, 7, -5, -32768, 3, -7, -3, -32768});
    // half turns: one difference of zero per axis keeps sign positive
    send_matrix(matrix_t'{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
    send_matrix(matrix_t'{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
    send_matrix(matrix_t'{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
    // quarter turns both ways about each axis
    send_matrix(matrix_t'{16384, 0, 0, 0, 0, -16384, 0, 16384, 0});
    send_matrix(matrix_t'{16384, 0, 0, 0, 0, 16384, 0, -16384, 0});
    send_matrix(matrix_t'{0, 0, 16384, 0, 16384, 0, -16384, 0, 0});
    send_matrix(matrix_t'{0, 0, -16384, 0, 16384, 0, 16384, 0, 0});
    send_matrix(matrix_t'{0, -16384, 0, 16384, 0, 0, 0, 0, 16384});
    send_matrix(matrix_t'{0, 16384, 0, -16384, 0, 0, 0, 0, 16384});
    // zero vector magnitudes with negative sign differences
    send_matrix(matrix_t'{16384, 0, -1, -1, 16384, 0, 0, -1, 16384});
    send_matrix(matrix_t'{16384, 32767, -32768, -32768, 16384, 32767, 32767, -32768, 16384});
    // largest sums per lane
    send_matrix(matrix_t'{32767, 0, 0, 0, -32768, 0, 0, 0, -32768});
    send_matrix(matrix_t'{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768});
    send_matrix(matrix_t'{-32768, 0, 0, 0, -32768, 0, 0, 0, 32767});
    send_matrix(matrix_t'{32767, 0, 0, 0, 32767, 0, 0, 0, 32767});
    // widest differences
    send_matrix(matrix_t'{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0});
    send_matrix(matrix_t'{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0});
    send_matrix({9{16'sh5555}});
    send_matrix({9{16'shaaaa}});
  endtask

  task automatic test_random_full(input int unsigned count);
    matrix_t mat;
    repeat (count) begin
      for (int k = 0; k < 9; k++)
        mat[k] = ($urandom_range(0, 3) == 0) ? corner_elem() : IN_W'($urandom);
      send_matrix(mat);
    end
  endtask

  task automatic test_random_unit(input int unsigned count);
    matrix_t mat;
    repeat (count) begin
      for (int k = 0; k < 9; k++) mat[k] = IN_W'(int'($urandom_range(0, 32768)) - 16384);
      send_matrix(mat);
    end
  endtask

  // signed axis permutations with small noise: proper and improper rotations
  task automatic test_near_rotation(input int unsigned count);
    matrix_t mat;
    int unsigned col [3];
    int noise;
    repeat (count) begin
      col[0] = $urandom_range(0, 2);
      col[1] = (col[0] + 1 + $urandom_range(0, 1)) % 3;
      col[2] = 3 - col[0] - col[1];
      noise = $urandom_range(0, 1) ? 64 : 2;
      for (int k = 0; k < 9; k++) mat[k] = IN_W'(int'($urandom_range(0, 2 * noise)) - noise);
      for (int r = 0; r < 3; r++)
        mat[r * 3 + col[r]] = IN_W'(int'(mat[r * 3 + col[r]])
                                    + ($urandom_range(0, 1) ? 16384 : -16384));
      send_matrix(mat);
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_gaps = 1'b1;
    test_random_full(count / 2);
    no_stalls = 1'b1;
    test_near_rotation(count - count / 2);
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  task automatic test_drain_pause(input int unsigned rounds);
    repeat (rounds) begin
      test_random_unit($urandom_range(1, 30));
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      quat_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      quat_ready <= 1'b1;
      if (!no_stalls && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin : quat_check
    quat_t want;
    if (!rst && quat_valid && quat_ready) begin
      if (pending_quats.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected quat transfer: w=%0d x=%0d y=%0d z=%0d",
                   quat_w, quat_x, quat_y, quat_z);
      end else begin
        want = pending_quats.pop_front();
        if (quat_w !== want.w || quat_x !== want.x || quat_y !== want.y
            || quat_z !== want.z) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("quat mismatch: exp w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, quat_w, quat_x, quat_y, quat_z);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed();
    test_random_full(400);
    test_drain_pause(8);
    test_random_unit(300);
    test_back_to_back(150);
    test_near_rotation(300);
    wait_drained();
    repeat (2 * LATENCY + 4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rmq_pkg.sv
hdl/rmq_isqrt.sv
hdl/rotation_matrix_to_quaternion_unit.sv
hdl/rmq_checker.sv
tb/tb_top.sv
